/* rtl/tdd_pkg.sv */
// Shared types and constants for the Taylor tree dedispersion block.
// Used by tdd_store, tdd_sum_unit and taylor_tree_dedispersion; no dependencies.
package tdd_pkg;

    // Default sizes of the channel-by-time store
    localparam int NUM_CHANNELS_DEF = 32;
    localparam int NUM_SAMPLES_DEF  = 256;

    // Field widths of the stream items
    localparam int CELL_W     = 21;
    localparam int OP_W       = 2;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 9;
    localparam int SAMPLE_W   = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // Command codes carried on the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // Result kinds carried on the output tuser
    typedef enum logic {
        KIND_DONE = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    // Second operand of the shared adder
    typedef enum logic {
        SUM_BPREV = 1'b0,
        SUM_A     = 1'b1
    } t_sum_sel;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDATA,
        ST_PAIR,
        ST_PRE,
        ST_FIRST,
        ST_LA,
        ST_LB,
        ST_DONE
    } t_state;

endpackage

/* rtl/tdd_store.sv */
// Channel row store: one write port and one registered read port.
// Depends on tdd_pkg for the cell width.
module tdd_store #(
    parameter int DEPTH  = tdd_pkg::NUM_CHANNELS_DEF *
                           (tdd_pkg::NUM_SAMPLES_DEF + 2 * tdd_pkg::NUM_CHANNELS_DEF),
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [tdd_pkg::CELL_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    output logic [tdd_pkg::CELL_W-1:0] o_rd_data
);

    logic [tdd_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tdd_pkg::CELL_W-1:0] r_rd_data;

    // Write one cell
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one cell, data valid the next cycle and held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/tdd_sum_unit.sv */
// Shared 21-bit adder of the tree sum, with its second operand selected.
// Depends on tdd_pkg for the cell width and the operand select type.
module tdd_sum_unit (
    input  logic [tdd_pkg::CELL_W-1:0] i_rd_data,
    input  logic [tdd_pkg::CELL_W-1:0] i_bprev,
    input  logic [tdd_pkg::CELL_W-1:0] i_a,
    input  tdd_pkg::t_sum_sel          i_sel,
    output logic [tdd_pkg::CELL_W-1:0] o_sum
);

    logic [tdd_pkg::CELL_W-1:0] operand;

    // Pick the partner of the freshly read cell
    always_comb begin
        case (i_sel)
            tdd_pkg::SUM_BPREV: operand = i_bprev;
            tdd_pkg::SUM_A:     operand = i_a;
            default:            operand = i_a;
        endcase
    end

    // Add and wrap at the cell width
    assign o_sum = i_rd_data + operand;

endmodule

/* rtl/taylor_tree_dedispersion.sv */
// Taylor tree dedispersion engine: command decode, tree sequencer, result register.
// Depends on tdd_pkg, tdd_store and tdd_sum_unit.
//
//  Port group   Dir  tdata / tuser contents (lowest bit first)
//  i_s_*        in   tdata: row[4:0], column[13:5], sample_value[29:14], zero[31:30]
//                    tuser: op[1:0]
//  o_m_*        out  tdata: cell_value[20:0], zero[23:21]; tuser: kind[0]
//
//  A sample write is done at its transfer; a read loads its result once ST_RDATA finds the result register free.
//  A run walks every row pair of every stage: ST_PAIR, ST_PRE and ST_FIRST set up each pair,
//  then ST_LA and ST_LB handle each column (NUM_SAMPLES + NUM_CHANNELS columns), as the
//  store has a single read port.
//  Input ready is low while a read or run is in progress; a finished read or run whose
//  result finds the result register still full waits there, but a write never waits for it.
//  Reset (synchronous, active low) clears the sequencer and the result register only.
module taylor_tree_dedispersion #(
    parameter int NUM_CHANNELS = tdd_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_SAMPLES  = tdd_pkg::NUM_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tdd_pkg::IN_DATA_W-1:0]  i_s_tdata,  // row, column, sample_value
    input  logic [tdd_pkg::OP_W-1:0]       i_s_tuser,  // op
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tdd_pkg::OUT_DATA_W-1:0] o_m_tdata,  // cell_value
    output logic                          o_m_tuser   // kind
);

    localparam int ROW_LEN = NUM_SAMPLES + 2 * NUM_CHANNELS;
    localparam int DEPTH   = NUM_CHANNELS * ROW_LEN;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int NPTS    = NUM_SAMPLES + NUM_CHANNELS;
    localparam int J_W     = $clog2(NPTS);
    localparam int R_W     = $clog2(NUM_CHANNELS);
    localparam int RB_W    = R_W + 1;
    localparam int CW      = R_W + 3;
    localparam int S_W     = $clog2(R_W + 1);
    localparam int CELL_W  = tdd_pkg::CELL_W;

    // Input field split
    logic [tdd_pkg::ROW_W-1:0]    in_row;
    logic [tdd_pkg::COL_W-1:0]    in_col;
    logic [tdd_pkg::SAMPLE_W-1:0] in_sample;
    logic                         s_accept;
    logic                         host_ok;
    logic [ADDR_W-1:0]            host_addr;

    assign in_row    = i_s_tdata[tdd_pkg::ROW_W-1:0];
    assign in_col    = i_s_tdata[tdd_pkg::ROW_W +: tdd_pkg::COL_W];
    assign in_sample = i_s_tdata[tdd_pkg::ROW_W + tdd_pkg::COL_W +: tdd_pkg::SAMPLE_W];
    assign s_accept  = i_s_tvalid && o_s_tready;
    assign host_ok   = (32'(in_row) < NUM_CHANNELS) && (32'(in_col) < ROW_LEN);
    assign host_addr = ADDR_W'(32'(in_row) * ROW_LEN + 32'(in_col));

    // Control registers
    tdd_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    // Payload registers
    tdd_pkg::t_kind    r_out_kind, n_out_kind;
    logic [CELL_W-1:0] r_out_cell, n_out_cell;
    logic              r_rd_ok, n_rd_ok;
    logic [R_W-1:0]    r_half, n_half;
    logic [S_W-1:0]    r_s, n_s;
    logic [R_W-1:0]    r_p, n_p;
    logic [RB_W-1:0]   r_sec_base, n_sec_base;
    logic [J_W-1:0]    r_j, n_j;
    logic [ADDR_W-1:0] r_pa, n_pa;
    logic [ADDR_W-1:0] r_pb, n_pb;
    logic [ADDR_W-1:0] r_wb, n_wb;
    logic [CELL_W-1:0] r_a, n_a;
    logic [CELL_W-1:0] r_bprev, n_bprev;

    // Store and adder connections
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CELL_W-1:0] wr_data, rd_data, sum;
    tdd_pkg::t_sum_sel sum_sel;

    // Pair row numbers: bit-reversed pair index within the section
    logic [R_W-1:0] rev_full, rev_p, ra, rb;
    logic           p_last, sec_more, stage_more, j_last;

    always_comb begin
        for (int k = 0; k < R_W; k++) begin
            rev_full[k] = r_p[R_W-1-k];
        end
    end

    assign rev_p      = R_W'(rev_full >> (R_W - int'(r_s)));
    assign ra         = R_W'(RB_W'(rev_p) + r_sec_base);
    assign rb         = ra + r_half;
    assign p_last     = (CW'(r_p) + CW'(1)) >= CW'(r_half);
    assign sec_more   = (CW'(r_sec_base) + (CW'(r_half) << 2)) <= CW'(NUM_CHANNELS);
    assign stage_more = (CW'(r_half) << 2) <= CW'(NUM_CHANNELS);
    assign j_last     = r_j == J_W'(NPTS - 1);

    // Result register can take a new result this cycle
    assign out_free = !r_out_valid || i_m_tready;

    assign sum_sel = (r_state == tdd_pkg::ST_LA) ? tdd_pkg::SUM_BPREV : tdd_pkg::SUM_A;

    tdd_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tdd_sum_unit u_sum (
        .i_rd_data (rd_data),
        .i_bprev   (r_bprev),
        .i_a       (r_a),
        .i_sel     (sum_sel),
        .o_sum     (sum)
    );

    // Sequencer: next state, store access and result register
    always_comb begin
        n_state    = r_state;
        n_out_valid = r_out_valid;
        n_out_kind = r_out_kind;
        n_out_cell = r_out_cell;
        n_rd_ok    = r_rd_ok;
        n_half     = r_half;
        n_s        = r_s;
        n_p        = r_p;
        n_sec_base = r_sec_base;
        n_j        = r_j;
        n_pa       = r_pa;
        n_pb       = r_pb;
        n_wb       = r_wb;
        n_a        = r_a;
        n_bprev    = r_bprev;
        wr_en      = 1'b0;
        wr_addr    = r_pa;
        wr_data    = sum;
        rd_en      = 1'b0;
        rd_addr    = r_pa;

        // Drop the result once it has been transferred
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tdd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (tdd_pkg::t_op'(i_s_tuser))
                        tdd_pkg::OP_WRITE: begin
                            wr_en   = host_ok;
                            wr_addr = host_addr;
                            wr_data = CELL_W'(in_sample);
                        end
                        tdd_pkg::OP_READ: begin
                            rd_en   = host_ok;
                            rd_addr = host_addr;
                            n_rd_ok = host_ok;
                            n_state = tdd_pkg::ST_RDATA;
                        end
                        tdd_pkg::OP_RUN: begin
                            n_half     = R_W'(1);
                            n_s        = '0;
                            n_p        = '0;
                            n_sec_base = '0;
                            n_state    = tdd_pkg::ST_PAIR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tdd_pkg::ST_RDATA: begin
                // Hold the read data until the result register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = tdd_pkg::KIND_READ;
                    n_out_cell  = r_rd_ok ? rd_data : '0;
                    n_state     = tdd_pkg::ST_IDLE;
                end
            end
            tdd_pkg::ST_PAIR: begin
                // Row base addresses of this pair
                n_pa    = ADDR_W'(32'(ra) * ROW_LEN);
                n_wb    = ADDR_W'(32'(rb) * ROW_LEN);
                n_state = tdd_pkg::ST_PRE;
            end
            tdd_pkg::ST_PRE: begin
                // Prefetch B[p]; later reads advance from B[p+1]
                rd_en   = 1'b1;
                rd_addr = r_wb + ADDR_W'(r_p);
                n_pb    = r_wb + ADDR_W'(r_p) + ADDR_W'(1);
                n_j     = '0;
                n_state = tdd_pkg::ST_FIRST;
            end
            tdd_pkg::ST_FIRST: begin
                n_bprev = rd_data;
                rd_en   = 1'b1;
                rd_addr = r_pa;
                n_state = tdd_pkg::ST_LA;
            end
            tdd_pkg::ST_LA: begin
                // A[j] arrives: write A[j] + B[j+p], fetch B[j+p+1]
                n_a     = rd_data;
                wr_en   = 1'b1;
                wr_addr = r_pa;
                n_pa    = r_pa + ADDR_W'(1);
                rd_en   = 1'b1;
                rd_addr = r_pb;
                n_state = tdd_pkg::ST_LB;
            end
            tdd_pkg::ST_LB: begin
                // B[j+p+1] arrives: write B[j] = A[j] + B[j+p+1], keep it for the next column
                wr_en   = 1'b1;
                wr_addr = r_wb;
                n_bprev = rd_data;
                n_wb    = r_wb + ADDR_W'(1);
                n_pb    = r_pb + ADDR_W'(1);
                if (j_last) begin
                    n_state = tdd_pkg::ST_PAIR;
                    if (!p_last) begin
                        n_p = r_p + R_W'(1);
                    end else begin
                        n_p = '0;
                        if (sec_more) begin
                            n_sec_base = r_sec_base + {r_half, 1'b0};
                        end else begin
                            n_sec_base = '0;
                            if (stage_more) begin
                                n_half = r_half << 1;
                                n_s    = r_s + S_W'(1);
                            end else if (out_free) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = tdd_pkg::KIND_DONE;
                                n_out_cell  = '0;
                                n_state     = tdd_pkg::ST_IDLE;
                            end else begin
                                n_state = tdd_pkg::ST_DONE;
                            end
                        end
                    end
                end else begin
                    n_j     = r_j + J_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_pa;
                    n_state = tdd_pkg::ST_LA;
                end
            end
            tdd_pkg::ST_DONE: begin
                // Hold the run completion until the result register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = tdd_pkg::KIND_DONE;
                    n_out_cell  = '0;
                    n_state     = tdd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and loop indices
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_cell <= n_out_cell;
        r_rd_ok    <= n_rd_ok;
        r_half     <= n_half;
        r_s        <= n_s;
        r_p        <= n_p;
        r_sec_base <= n_sec_base;
        r_j        <= n_j;
        r_pa       <= n_pa;
        r_pb       <= n_pb;
        r_wb       <= n_wb;
        r_a        <= n_a;
        r_bprev    <= n_bprev;
    end

    assign o_s_tready = (r_state == tdd_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = tdd_pkg::OUT_DATA_W'(r_out_cell);
    assign o_m_tuser  = r_out_kind;

    // The two rows of a pair never collide between the write and read ports
    a_pair_rows_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdd_pkg::ST_LA || r_state == tdd_pkg::ST_LB) |-> (wr_addr != rd_addr))
        else $error("tree step writes and reads the same cell");

    // A result appears only at the end of a read or of a whole run
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |->
            ($past(r_state) == tdd_pkg::ST_RDATA || $past(r_state) == tdd_pkg::ST_LB ||
             $past(r_state) == tdd_pkg::ST_DONE))
        else $error("result raised outside read or run completion");

    // A run command holds off further input
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser == tdd_pkg::OP_RUN) |=> !o_s_tready)
        else $error("input ready right after a run command");

    // Pair index stays inside the section
    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdd_pkg::ST_PAIR || r_state == tdd_pkg::ST_LB) |-> (r_p < r_half))
        else $error("pair index beyond pairs per section");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for taylor_tree_dedispersion: loads, reads and tree-sum runs.
// Depends on tdd_pkg and the taylor_tree_dedispersion RTL only.
module testbench;

    localparam int NUM_CH      = tdd_pkg::NUM_CHANNELS_DEF;
    localparam int NUM_SMP     = tdd_pkg::NUM_SAMPLES_DEF;
    localparam int ROW_LEN     = NUM_SMP + 2 * NUM_CH;
    localparam int SUM_COLS    = NUM_SMP + NUM_CH;
    localparam int NUM_CELLS   = NUM_CH * ROW_LEN;
    localparam int COL_MAX     = (1 << tdd_pkg::COL_W) - 1;
    localparam int STALL_LIMIT = 250000;
    localparam int DRAIN_CYCLES = 16;

    // Command code outside the defined set; the block must drop it
    localparam logic [tdd_pkg::OP_W-1:0] OP_NONE = 2'd3;

    typedef struct {
        tdd_pkg::t_kind             kind;
        logic [tdd_pkg::CELL_W-1:0] cell_value;
    } t_reply;

    // Shadow copy of the cell store plus the queue of replies still owed by the block
    class t_tree_sum_board;
        logic [tdd_pkg::CELL_W-1:0] shadow_cells [NUM_CELLS];
        t_reply                     pending_replies [$];
        int unsigned                error_count;

        function new();
            foreach (shadow_cells[i]) shadow_cells[i] = '0;
            error_count = 0;
        endfunction

        function int unsigned bit_rev(int unsigned v, int unsigned nbits);
            int unsigned r;
            r = 0;
            for (int unsigned i = 0; i < nbits; i++) begin
                r = (r << 1) | (v & 1);
                v = v >> 1;
            end
            return r;
        endfunction

        // Walk every stage of the tree in place, reading old values column by column
        function void sum_tree();
            int unsigned                stages, m, base, ra, rb;
            logic [tdd_pkg::CELL_W-1:0] av;
            stages = 0;
            while ((2 << stages) <= NUM_CH) stages++;
            for (int unsigned s = 0; s < stages; s++) begin
                m = 2 << s;
                for (int unsigned sec = 0; sec < NUM_CH / m; sec++) begin
                    base = sec * m;
                    for (int unsigned p = 0; p < m / 2; p++) begin
                        ra = (bit_rev(2 * p, s + 1) + base) * ROW_LEN;
                        rb = (bit_rev(2 * p + 1, s + 1) + base) * ROW_LEN;
                        for (int unsigned j = 0; j < SUM_COLS; j++) begin
                            av = shadow_cells[ra + j];
                            shadow_cells[ra + j] = av + shadow_cells[rb + j + p];
                            shadow_cells[rb + j] = av + shadow_cells[rb + j + p + 1];
                        end
                    end
                end
            end
        endfunction

        // Apply one accepted command and queue the reply it owes
        function void note_command(logic [tdd_pkg::OP_W-1:0] op,
                                   logic [tdd_pkg::ROW_W-1:0] row,
                                   logic [tdd_pkg::COL_W-1:0] col,
                                   logic [tdd_pkg::SAMPLE_W-1:0] value);
            t_reply      reply;
            bit          in_range;
            int unsigned idx;
            in_range = (row < NUM_CH) && (col < ROW_LEN);
            idx = row * ROW_LEN + col;
            case (op)
                tdd_pkg::OP_WRITE: begin
                    if (in_range) shadow_cells[idx] = tdd_pkg::CELL_W'(value);
                end
                tdd_pkg::OP_RUN: begin
                    sum_tree();
                    reply.kind = tdd_pkg::KIND_DONE;
                    reply.cell_value = '0;
                    pending_replies.push_back(reply);
                end
                tdd_pkg::OP_READ: begin
                    reply.kind = tdd_pkg::KIND_READ;
                    reply.cell_value = in_range ? shadow_cells[idx] : '0;
                    pending_replies.push_back(reply);
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted result with the oldest owed reply
        function void check_result(tdd_pkg::t_kind kind, logic [tdd_pkg::CELL_W-1:0] value);
            t_reply want;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d cell_value %0d",
                         $time, kind, value);
                error_count++;
                return;
            end
            want = pending_replies.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: kind mismatch, expected %0d actual %0d",
                         $time, want.kind, kind);
                error_count++;
            end
            if (value !== want.cell_value) begin
                $display("%0t: cell_value mismatch, expected %0d actual %0d",
                         $time, want.cell_value, value);
                error_count++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [tdd_pkg::IN_DATA_W-1:0]  i_s_tdata  = '0;   // row, column, sample_value, zero pad
    logic [tdd_pkg::OP_W-1:0]       i_s_tuser  = tdd_pkg::OP_WRITE;  // op
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [tdd_pkg::OUT_DATA_W-1:0] o_m_tdata;         // cell_value, zero pad
    logic                           o_m_tuser;         // kind

    t_tree_sum_board tree_sb = new();

    int unsigned src_idle_pct   = 10;
    int unsigned sink_stall_pct = 46;
    int unsigned idle_cycles    = 0;
    bit          cell_known [NUM_CELLS];
    int unsigned known_cells [$];

    taylor_tree_dedispersion #(
        .NUM_CHANNELS (NUM_CH),
        .NUM_SAMPLES  (NUM_SMP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watch both sides with pre-edge values; stop the run when transfers dry up
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                tree_sb.note_command(i_s_tuser, i_s_tdata[4:0], i_s_tdata[13:5],
                                     i_s_tdata[29:14]);
            if (o_m_tvalid && i_m_tready)
                tree_sb.check_result(tdd_pkg::t_kind'(o_m_tuser),
                                     o_m_tdata[tdd_pkg::CELL_W-1:0]);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Offer one command, idling first at random, and hold it until the transfer
    task automatic send_item(input logic [tdd_pkg::OP_W-1:0] op, input int unsigned row,
                             input int unsigned col, input int unsigned value);
        int unsigned idx;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, tdd_pkg::SAMPLE_W'(value), tdd_pkg::COL_W'(col),
                       tdd_pkg::ROW_W'(row)};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        idx = row * ROW_LEN + col;
        if (op == tdd_pkg::OP_WRITE && row < NUM_CH && col < ROW_LEN && !cell_known[idx]) begin
            cell_known[idx] = 1'b1;
            known_cells.push_back(idx);
        end
    endtask

    // Read back a cell that has already been written
    task automatic read_known();
        int unsigned idx;
        idx = known_cells[$urandom_range(known_cells.size() - 1)];
        send_item(tdd_pkg::OP_READ, idx / ROW_LEN, idx % ROW_LEN, $urandom_range(16'hFFFF));
    endtask

    // Hold off the sender until every owed reply has arrived
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (tree_sb.outstanding() != 0);
        @(posedge i_clk);
    endtask

    function automatic int unsigned pick_sample(input int unsigned mode);
        int unsigned roll;
        roll = $urandom_range(99);
        case (mode)
            0: begin
                if (roll < 10) return 0;
                if (roll < 20) return 16'hFFFF;
                return $urandom_range(16'hFFFF);
            end
            1: return (roll < 97) ? 16'hFFFF : $urandom_range(16'hFFFF);
            default: return $urandom_range(255);
        endcase
    endfunction

    // Mixed writes, reads of written cells, out-of-range accesses and undefined codes
    task automatic random_mix(input int unsigned count, input int unsigned mode);
        int unsigned roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 40 || (roll < 80 && known_cells.size() == 0))
                send_item(tdd_pkg::OP_WRITE, $urandom_range(NUM_CH - 1),
                          $urandom_range(ROW_LEN - 1), pick_sample(mode));
            else if (roll < 80)
                read_known();
            else if (roll < 88)
                send_item(tdd_pkg::OP_READ, $urandom_range(NUM_CH - 1),
                          $urandom_range(ROW_LEN, COL_MAX), $urandom_range(16'hFFFF));
            else if (roll < 94)
                send_item(tdd_pkg::OP_WRITE, $urandom_range(NUM_CH - 1),
                          $urandom_range(ROW_LEN, COL_MAX), $urandom_range(16'hFFFF));
            else
                send_item(OP_NONE, $urandom_range(NUM_CH - 1), $urandom_range(COL_MAX),
                          $urandom_range(16'hFFFF));
        end
    endtask

    // Write every cell of the store once, with a few read-backs along the way
    task automatic fill_store(input int unsigned mode);
        for (int unsigned idx = 0; idx < NUM_CELLS; idx++) begin
            send_item(tdd_pkg::OP_WRITE, idx / ROW_LEN, idx % ROW_LEN, pick_sample(mode));
            if ($urandom_range(99) < 3) read_known();
        end
    endtask

    // Mix in some traffic, run the tree on the fully written store, then read the sums back
    task automatic run_phase(input int unsigned mode);
        random_mix(40, mode);
        wait_idle();
        send_item(tdd_pkg::OP_RUN, $urandom_range(NUM_CH - 1), $urandom_range(COL_MAX),
                  $urandom_range(16'hFFFF));
        send_item(tdd_pkg::OP_READ, 0, 0, 0);
        send_item(tdd_pkg::OP_READ, NUM_CH - 1, SUM_COLS - 1, 16'hFFFF);
        send_item(tdd_pkg::OP_READ, NUM_CH - 1, ROW_LEN - 1, 0);
        repeat (60) read_known();
        random_mix(80, mode);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, both out-of-range cases and the undefined code
        send_item(tdd_pkg::OP_WRITE, 0, 0, 16'h0000);
        send_item(tdd_pkg::OP_WRITE, NUM_CH - 1, ROW_LEN - 1, 16'hFFFF);
        send_item(tdd_pkg::OP_WRITE, 0, ROW_LEN - 1, 16'hAAAA);
        send_item(tdd_pkg::OP_WRITE, NUM_CH - 1, 0, 16'h5555);
        send_item(tdd_pkg::OP_READ, 0, 0, 16'hFFFF);
        send_item(tdd_pkg::OP_READ, NUM_CH - 1, ROW_LEN - 1, 16'h0000);
        send_item(tdd_pkg::OP_READ, 0, ROW_LEN - 1, 16'h0000);
        send_item(tdd_pkg::OP_READ, NUM_CH - 1, 0, 16'h0000);
        send_item(tdd_pkg::OP_WRITE, NUM_CH - 1, COL_MAX, 16'hFFFF);
        send_item(tdd_pkg::OP_WRITE, 0, ROW_LEN, 16'h1234);
        send_item(tdd_pkg::OP_READ, NUM_CH - 1, COL_MAX, 16'hFFFF);
        send_item(tdd_pkg::OP_READ, 0, ROW_LEN, 16'h0000);
        send_item(OP_NONE, NUM_CH - 1, COL_MAX, 16'hFFFF);
        send_item(OP_NONE, 0, 0, 16'h0000);
        send_item(tdd_pkg::OP_WRITE, 0, 0, 16'hFFFF);
        send_item(tdd_pkg::OP_READ, 0, 0, 16'h0000);
        send_item(tdd_pkg::OP_READ, NUM_CH - 1, ROW_LEN - 1, 16'h0000);

        // Load near-full-scale samples so the first run reaches the largest sums
        fill_store(1);
        run_phase(1);
        src_idle_pct   = 46;
        sink_stall_pct = 10;
        run_phase(0);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_phase(2);

        // Let stray results surface before the verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tree_sb.error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
